// ----- src/ffba_pkg.sv -----
// ffba_pkg: shared constants, codes and types of the first-fit bitmap allocator
// bitmap geometry, command and status codes, register indexes, scan result type
// no dependencies
`default_nettype none

package ffba_pkg;

    // bitmap geometry
    localparam int MAX_SLOTS = 32768;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    // field widths
    localparam int BLOCK_W   = 32;
    localparam int SLOT_W    = 15;
    localparam int COUNT_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W:0] MAX_SLOTS_CNT = (COUNT_W + 1)'(MAX_SLOTS);

    typedef logic [WORD_BITS-1:0] map_word_t;
    typedef logic [WORD_AW-1:0]   word_addr_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RESERVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_BLOCK   = 1'b0,
        REG_SLOTS_IN_USE = 1'b1
    } cfg_reg_t;

    // result of one word check
    typedef struct packed {
        logic     found;
        bit_idx_t bit_idx;
    } scan_res_t;

endpackage

`default_nettype wire

// ----- src/ffba_ram.sv -----
// ffba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/ffba_scan.sv -----
// ffba_scan: finds the lowest free bit of one bitmap word
// bits past the usable count in the last word count as used; needs ffba_pkg
`default_nettype none

module ffba_scan (
    input  wire logic                        is_last,
    input  wire ffba_pkg::bit_idx_t          last_bit,
    input  wire ffba_pkg::map_word_t         word,
    output ffba_pkg::scan_res_t              res
);
    import ffba_pkg::*;

    map_word_t free_bits;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !word[b] && (!is_last || (BIT_W'(b) <= last_bit));
        end
    end

    // priority encode, lowest free bit wins
    always_comb
    begin
        res.found   = |free_bits;
        res.bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                res.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/first_fit_bitmap_block_allocator_top.sv -----
// first_fit_bitmap_block_allocator_top: first-fit slot allocator over a used bitmap
// allocate reads then checks each bitmap word in turn until a free bit or the last word,
// reserve reads then writes back the slot's word, zero-count allocate and out-of-range
// reserve go straight to the result; the result beat waits while out_ready stalls; one command at a time
// reset: clears the 1024-word bitmap one word a cycle, with in_ready low until the sweep ends
// depends on ffba_pkg, ffba_ram, ffba_scan
`default_nettype none

module first_fit_bitmap_block_allocator_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data,
    // command channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [ffba_pkg::SLOT_W-1:0]      slot_index,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ffba_pkg::BLOCK_W-1:0]          block_number,
    output logic [ffba_pkg::SLOT_W-1:0]           slot_found,
    output logic [ffba_pkg::STATUS_W-1:0]         status
);
    import ffba_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_SCAN_RD = 7'b0000100,
        S_SCAN_CK = 7'b0001000,
        S_RSV_RD  = 7'b0010000,
        S_RSV_WR  = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [BLOCK_W-1:0] base_reg;
    logic [COUNT_W-1:0] slots_reg;

    // working registers
    word_addr_t         clr_reg, clr_next;
    word_addr_t         word_reg, word_next;
    cmd_t               cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    status_t            stat_reg, stat_next;

    // result beat registers
    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] blk_out_reg, blk_out_next;
    logic [SLOT_W-1:0]  slot_out_reg, slot_out_next;
    status_t            stat_out_reg, stat_out_next;

    // usable count, saturated at the bitmap size
    logic [COUNT_W-1:0] usable;
    logic [COUNT_W-1:0] usable_m1;
    word_addr_t         last_word;
    bit_idx_t           last_bit;

    // ram ports
    logic       wr_en;
    word_addr_t wr_addr;
    map_word_t  wr_data;
    word_addr_t rd_addr;
    map_word_t  rd_data;

    scan_res_t  scan;
    logic       is_last;
    logic       out_free;
    logic       in_fire;

    assign usable    = ({1'b0, slots_reg} > MAX_SLOTS_CNT) ? MAX_SLOTS_CNT[COUNT_W-1:0]
                                                           : slots_reg;
    assign usable_m1 = usable - COUNT_W'(1);
    assign last_word = usable_m1[BIT_W +: WORD_AW];
    assign last_bit  = usable_m1[BIT_W-1:0];
    assign is_last   = (word_reg == last_word);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    // output register can take a new beat
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign block_number = blk_out_reg;
    assign slot_found   = slot_out_reg;
    assign status       = stat_out_reg;

    // scan walks word_reg, reserve reads the word that holds the given slot
    assign rd_addr = (state_reg == S_SCAN_RD) ? word_reg : idx_reg[BIT_W +: WORD_AW];

    ffba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffba_scan u_scan (
        .is_last  (is_last),
        .last_bit (last_bit),
        .word     (rd_data),
        .res      (scan)
    );

    // configuration writes, to be made only while idle by contract; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            slots_reg <= COUNT_W'(MAX_SLOTS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_BLOCK:   base_reg  <= cfg_data;
                REG_SLOTS_IN_USE: slots_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        word_next      = word_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        blk_out_next   = blk_out_reg;
        slot_out_next  = slot_out_reg;
        stat_out_next  = stat_out_reg;
        wr_en          = 1'b0;
        wr_addr        = word_reg;
        wr_data        = rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the bitmap to all free after reset
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + WORD_AW'(1);
                if (clr_reg == WORD_AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = cmd_t'(command);
                    idx_next  = slot_index;
                    word_next = '0;
                    if (cmd_t'(command) == CMD_ALLOC)
                    begin
                        slot_next = '0;
                        if (usable == '0)
                        begin
                            stat_next  = STATUS_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        slot_next = slot_index;
                        if ({1'b0, slot_index} >= usable)
                        begin
                            stat_next  = STATUS_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RSV_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                // read address goes out this cycle, data checked next
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                if (scan.found)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = word_reg;
                    wr_data    = rd_data | (map_word_t'(1) << scan.bit_idx);
                    slot_next  = {word_reg, scan.bit_idx};
                    stat_next  = STATUS_OK;
                    state_next = S_DONE;
                end
                else if (is_last)
                begin
                    stat_next  = STATUS_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WORD_AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_RSV_RD:
            begin
                state_next = S_RSV_WR;
            end
            S_RSV_WR:
            begin
                // read-modify-write of the word holding the slot
                wr_en      = 1'b1;
                wr_addr    = idx_reg[BIT_W +: WORD_AW];
                wr_data    = rd_data | (map_word_t'(1) << idx_reg[BIT_W-1:0]);
                stat_next  = STATUS_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_out_next  = slot_reg;
                    stat_out_next  = stat_reg;
                    // only a successful allocate returns a block number
                    if (cmd_reg == CMD_ALLOC && stat_reg == STATUS_OK)
                    begin
                        blk_out_next = base_reg + BLOCK_W'(slot_reg);
                    end
                    else
                    begin
                        blk_out_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        stat_reg     <= stat_next;
        blk_out_reg  <= blk_out_next;
        slot_out_reg <= slot_out_next;
        stat_out_reg <= stat_out_next;
    end

endmodule

`default_nettype wire
